@@ design/first_hit_depth_colormap_assert.svh @@
// Assertion macros for the first-hit depth colormap block.
// No dependencies; included by the files that assert.
`ifndef FIRST_HIT_DEPTH_COLORMAP_ASSERT_SVH
`define FIRST_HIT_DEPTH_COLORMAP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FHDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled in reset
`define FHDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ design/fhdc_pkg.sv @@
// Shared types and constants of the first-hit depth colormap block.
// No dependencies.
package fhdc_pkg;

    localparam int VOXEL_W = 16;
    localparam int CHAN_W  = 8;

    typedef logic [VOXEL_W-1:0] voxel_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    // register map
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_HIT_THRESHOLD = 3'd0;

    localparam voxel_t HIT_THRESHOLD_RESET = 16'd19661;

endpackage

@@ design/fhdc_voxel_if.sv @@
// Voxel request channel: valid/ready plus one Q0.16 voxel value.
// Depends on fhdc_pkg.
interface fhdc_voxel_if
    import fhdc_pkg::*;
();
    logic   valid;
    logic   ready;
    voxel_t voxel_value;

    modport source (output valid, output voxel_value, input ready);
    modport sink   (input valid, input voxel_value, output ready);
endinterface

@@ design/fhdc_pixel_if.sv @@
// Pixel request channel: valid/ready plus three 8-bit color channels.
// Depends on fhdc_pkg.
interface fhdc_pixel_if
    import fhdc_pkg::*;
();
    logic  valid;
    logic  ready;
    chan_t first_channel;
    chan_t second_channel;
    chan_t third_channel;

    modport source (output valid, output first_channel, output second_channel,
                    output third_channel, input ready);
    modport sink   (input valid, input first_channel, input second_channel,
                    input third_channel, output ready);
endinterface

@@ design/first_hit_depth_colormap.sv @@
// First-hit depth search over a voxel column with jet colormap output.
// Depends on fhdc_pkg, fhdc_voxel_if, fhdc_pixel_if, first_hit_depth_colormap_assert.svh.
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+-----------
//  voxels   | in  | voxel_value[15:0]                              | valid/ready
//  pixels   | out | first_channel, second_channel, third_channel   | valid/ready
//  apb      | in  | hit_threshold at 0x0                           | pready = 1
//
// One voxel per cycle unless stalled; one pixel per GRID_SIZE voxels, registered with
// the column's last voxel. Colormap is a compare/constant-multiply per channel
// straight off the column state into the pixel register.
// Reset clears the column state and the pixel valid; threshold goes to 19661.
// A stalled pixel blocks only the next column's last voxel; others keep flowing.
`include "first_hit_depth_colormap_assert.svh"

module first_hit_depth_colormap
    import fhdc_pkg::*;
#(
    parameter int GRID_SIZE = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    fhdc_voxel_if.sink            voxels,
    fhdc_pixel_if.source          pixels,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int DW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int WW = DW + 5;
    localparam logic [DW-1:0] LAST_POS = DW'(GRID_SIZE - 1);
    localparam logic signed [WW-1:0] G1 = WW'(GRID_SIZE);
    localparam logic signed [WW-1:0] G2 = WW'(2 * GRID_SIZE);
    localparam logic signed [WW-1:0] G3 = WW'(3 * GRID_SIZE);

    // 255 * tent(w / 4G), truncated; 2G is a power of two so the divide is a shift
    function automatic chan_t tent255(input logic signed [WW-1:0] w);
        logic signed [WW-1:0] num;
        logic [WW+7:0]        prod;
        chan_t                res;
        num  = '0;
        prod = '0;
        res  = '0;
        if (w <= -G3) begin
            res = '0;
        end else if (w <= -G1) begin
            num  = w + G3;
            prod = (WW+8)'($unsigned(num)) * (WW+8)'(255);
            res  = prod[DW+8:DW+1];
        end else if (w <= G1) begin
            res = 8'd255;
        end else if (w <= G3) begin
            num  = G3 - w;
            prod = (WW+8)'($unsigned(num)) * (WW+8)'(255);
            res  = prod[DW+8:DW+1];
        end else begin
            res = '0;
        end
        return res;
    endfunction

    voxel_t          thresh_reg,  thresh_next;
    logic [DW-1:0]   pos_reg,     pos_next;
    logic            found_reg,   found_next;
    logic [DW-1:0]   depth_reg,   depth_next;
    logic            valid_reg,   valid_next;
    chan_t           ch0_reg,     ch0_next;
    chan_t           ch1_reg,     ch1_next;
    chan_t           ch2_reg,     ch2_next;

    logic                 cfg_wr;
    logic                 in_fire;
    logic                 last_item;
    logic                 hit;
    logic                 col_found;
    logic [DW-1:0]        col_depth;
    logic signed [WW-1:0] d_val;
    logic signed [WW-1:0] w_val;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HIT_THRESHOLD[2]);
    assign prdata = (paddr[2] == REG_HIT_THRESHOLD[2]) ? {16'd0, thresh_reg} : 32'd0;

    assign last_item     = (pos_reg == LAST_POS);
    assign voxels.ready  = !last_item || !valid_reg || pixels.ready;
    assign in_fire       = voxels.valid && voxels.ready;

    assign hit       = (voxels.voxel_value > thresh_reg);
    assign col_found = found_reg || hit;
    assign col_depth = found_reg ? depth_reg : pos_reg;

    always_comb
    begin
        // no surface: d = -1
        d_val = col_found ? $signed(WW'(col_depth)) : -$signed(WW'(1));
        w_val = ((d_val <<< 1) + $signed(WW'(1)) - G1) <<< 2;
    end

    always_comb
    begin
        thresh_next = cfg_wr ? pwdata[VOXEL_W-1:0] : thresh_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        depth_next  = depth_reg;
        valid_next  = valid_reg && !pixels.ready;
        ch0_next    = ch0_reg;
        ch1_next    = ch1_reg;
        ch2_next    = ch2_reg;
        if (in_fire) begin
            if (last_item) begin
                pos_next   = '0;
                found_next = 1'b0;
                depth_next = '0;
                valid_next = 1'b1;
                ch0_next   = tent255(w_val + G2);
                ch1_next   = tent255(w_val);
                ch2_next   = tent255(w_val - G2);
            end else begin
                pos_next   = pos_reg + DW'(1);
                found_next = col_found;
                depth_next = col_depth;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            thresh_reg <= HIT_THRESHOLD_RESET;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
            depth_reg  <= '0;
            valid_reg  <= 1'b0;
        end else begin
            thresh_reg <= thresh_next;
            pos_reg    <= pos_next;
            found_reg  <= found_next;
            depth_reg  <= depth_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch0_reg <= ch0_next;
        ch1_reg <= ch1_next;
        ch2_reg <= ch2_next;
    end

    assign pixels.valid          = valid_reg;
    assign pixels.first_channel  = ch0_reg;
    assign pixels.second_channel = ch1_reg;
    assign pixels.third_channel  = ch2_reg;

    `FHDC_ASSERT_NEXT(a_last_gives_pixel, clk, rst_n, in_fire && last_item, valid_reg)
    `FHDC_ASSERT_NEXT(a_last_clears_column, clk, rst_n, in_fire && last_item,
        pos_reg == '0 && !found_reg)
    `FHDC_ASSERT_NOW(a_stall_blocks_last, clk, rst_n,
        valid_reg && !pixels.ready && last_item, !voxels.ready)
    `FHDC_ASSERT_NEXT(a_pos_advances, clk, rst_n, in_fire && !last_item,
        pos_reg == $past(pos_reg) + DW'(1))

endmodule

@@ tb/fhdc_pixel_checker.sv @@
`timescale 1ns / 100ps
// Checker for first_hit_depth_colormap: watches the voxel, pixel and register ports,
// predicts every pixel from the accepted voxels and compares it field by field.
// Depends on fhdc_pkg, fhdc_voxel_if and fhdc_pixel_if.
module fhdc_pixel_checker
    import fhdc_pkg::*;
#(
    parameter int GRID = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    fhdc_voxel_if                 vox,
    fhdc_pixel_if                 pix,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic [31:0]           prdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending,
    output int                    pixels_checked
);

    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    pixel_t     expected_pixels[$];
    voxel_t     threshold;
    logic [7:0] depth_pos;
    bit         surface_seen;
    logic [7:0] surface_at;

    // 255 * tent(w / (4*GRID)), truncated; all numerators are non-negative
    function automatic chan_t jet_level(int w);
        if (w <= -3 * GRID) return '0;
        if (w <= -GRID) return chan_t'((255 * (w + 3 * GRID)) / (2 * GRID));
        if (w <= GRID) return 8'd255;
        if (w <= 3 * GRID) return chan_t'((255 * (3 * GRID - w)) / (2 * GRID));
        return '0;
    endfunction

    function automatic pixel_t depth_color(int d);
        int     w;
        pixel_t p;
        w = 4 * (2 * d + 1 - GRID);
        p.blue  = jet_level(w + 2 * GRID);
        p.green = jet_level(w);
        p.red   = jet_level(w - 2 * GRID);
        return p;
    endfunction

    task automatic report(string what, longint want, longint got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what,
                         want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        pixel_t want;
        if (!rst_n) begin
            expected_pixels.delete();
            threshold      = HIT_THRESHOLD_RESET;
            depth_pos      = '0;
            surface_seen   = 1'b0;
            surface_at     = '0;
            fail_count     = 0;
            pending        = 0;
            pixels_checked = 0;
        end else begin
            if (pix.valid && pix.ready) begin
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t pixel %0d/%0d/%0d with no expectation waiting",
                                 $realtime, pix.first_channel, pix.second_channel,
                                 pix.third_channel);
                end else begin
                    want = expected_pixels.pop_front();
                    report("first_channel", want.blue, pix.first_channel);
                    report("second_channel", want.green, pix.second_channel);
                    report("third_channel", want.red, pix.third_channel);
                    pixels_checked++;
                end
            end

            // voxel uses the threshold in force before a write at this same edge
            if (vox.valid && vox.ready) begin
                if (!surface_seen && vox.voxel_value > threshold) begin
                    surface_seen = 1'b1;
                    surface_at   = depth_pos;
                end
                if (int'(depth_pos) + 1 < GRID) begin
                    depth_pos = depth_pos + 8'd1;
                end else begin
                    expected_pixels = {expected_pixels,
                        depth_color(surface_seen ? int'(surface_at) : -1)};
                    depth_pos    = '0;
                    surface_seen = 1'b0;
                    surface_at   = '0;
                end
            end

            if (psel && penable && pready && paddr == REG_HIT_THRESHOLD) begin
                if (pwrite)
                    threshold = pwdata[VOXEL_W-1:0];
                else
                    report("hit_threshold readback", {16'd0, threshold}, prdata);
            end

            pending = expected_pixels.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the first_hit_depth_colormap testbench: clock, reset, voxel and register
// stimulus, pixel back-pressure and the verdict. Depends on fhdc_pkg, the channel
// interfaces, the block itself and fhdc_pixel_checker.
module testbench;
    import fhdc_pkg::*;

    localparam int COLUMN_DEPTH = 32;
    localparam int LONG_HOLD    = 300;
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_REG_ADDR = 3'd4;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int pixels_checked;

    voxel_t cur_thr;
    bit     hold_pixels;
    int     voxels_sent;
    int     columns_sent;
    int     thr_settings;
    int     long_holds;

    fhdc_voxel_if vox ();
    fhdc_pixel_if pix ();

    first_hit_depth_colormap #(
        .GRID_SIZE (COLUMN_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .voxels  (vox),
        .pixels  (pix),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fhdc_pixel_checker #(
        .GRID (COLUMN_DEPTH)
    ) pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .vox            (vox),
        .pix            (pix),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_checked (pixels_checked)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic send_voxel(input voxel_t v, input int gap);
        @(negedge clk);
        if (gap > 0) begin
            vox.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vox.valid       <= 1'b1;
        vox.voxel_value <= v;
        do @(posedge clk); while (!vox.ready);
        voxels_sent++;
    endtask

    task automatic send_run(input voxel_t v, input int count);
        repeat (count) send_voxel(v, pick_gap());
    endtask

    // hit_at < 0 without noise: no voxel above threshold; noise: every voxel fully random
    task automatic send_column(input int hit_at, input bit noise, input bit burst);
        int     pos;
        voxel_t v;
        for (pos = 0; pos < COLUMN_DEPTH; pos++)
        begin
            if (noise || (hit_at >= 0 && pos > hit_at))
                v = voxel_t'($urandom);
            else if (pos == hit_at)
                v = (cur_thr == 16'hFFFF) ? 16'hFFFF
                    : voxel_t'($urandom_range(65535, int'(cur_thr) + 1));
            else
                v = voxel_t'($urandom_range(int'(cur_thr), 0));
            send_voxel(v, burst ? 0 : pick_gap());
        end
        columns_sent++;
    endtask

    // block may sit mid-column with nothing pending; give it time to settle
    task automatic wait_idle();
        @(negedge clk);
        vox.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_threshold(input logic [31:0] data);
        apb_access(1'b1, REG_HIT_THRESHOLD, data);
        apb_access(1'b0, REG_HIT_THRESHOLD, '0);
        cur_thr = data[VOXEL_W-1:0];
        thr_settings++;
    endtask

    // pixel sink: random ready pattern, plus one long hold-off on request
    initial
    begin : pixel_sink
        int n;
        pix.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_pixels) begin
                pix.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_pixels = 1'b0;
                long_holds++;
            end else if ($urandom_range(9, 0) == 0) begin
                pix.ready <= 1'b1;
                repeat (60) @(negedge clk);
            end else if ($urandom_range(3, 0) != 0) begin
                pix.ready <= 1'b1;
                n = $urandom_range(20, 1);
                repeat (n) @(negedge clk);
            end else begin
                pix.ready <= 1'b0;
                n = pick_gap() + 1;
                repeat (n) @(negedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int col;
        int r;
        logic [15:0] next_thr;

        rst_n           = 1'b0;
        vox.valid       = 1'b0;
        vox.voxel_value = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        cur_thr         = HIT_THRESHOLD_RESET;
        hold_pixels     = 1'b0;
        voxels_sent     = 0;
        columns_sent    = 0;
        thr_settings    = 0;
        long_holds      = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset threshold readback, first hit at front and back, no hit,
        // a voxel equal to the threshold, a threshold change mid-column,
        // a write to an unmapped register, and the extreme thresholds
        apb_access(1'b0, REG_HIT_THRESHOLD, '0);
        send_run(16'hFFFF, 1);
        send_run(16'h0000, 31);
        send_run(16'h0000, 31);
        send_run(16'hFFFF, 1);
        send_run(16'h0000, 32);
        send_run(HIT_THRESHOLD_RESET, 5);
        send_run(HIT_THRESHOLD_RESET + 16'd1, 1);
        send_run(16'h0000, 26);
        send_run(16'd100, 10);
        wait_idle();
        set_threshold(32'd0);
        send_run(16'h0000, 10);
        send_run(16'h0001, 1);
        send_run(16'hFFFF, 11);
        wait_idle();
        apb_access(1'b1, UNMAPPED_REG_ADDR, 32'h0000_FFFF);
        apb_access(1'b0, REG_HIT_THRESHOLD, '0);
        send_run(16'h0001, 32);
        wait_idle();
        set_threshold(32'hA5A5_FFFF);
        send_run(16'hFFFF, 32);
        columns_sent += 7;

        // random columns under a series of thresholds, extremes included
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: next_thr = 16'd0;
                1: next_thr = 16'hFFFF;
                3: next_thr = 16'd1;
                4: next_thr = 16'h8000;
                6: next_thr = HIT_THRESHOLD_RESET;
                default: next_thr = 16'($urandom);
            endcase
            wait_idle();
            set_threshold({16'($urandom), next_thr});
            for (col = 0; col < 6; col++)
            begin
                if (phase == 2 && col == 1) hold_pixels = 1'b1;
                if (phase == 4 && col == 3) wait_idle();
                r = $urandom_range(99, 0);
                if (r < 10)
                    send_column(-1, 1'b1, $urandom_range(3, 0) == 0);
                else if (r < 25)
                    send_column(-1, 1'b0, $urandom_range(3, 0) == 0);
                else
                    send_column($urandom_range(COLUMN_DEPTH - 1, 0), 1'b0,
                                $urandom_range(3, 0) == 0);
            end
        end

        wait_idle();
        repeat (8) @(negedge clk);

        $display("Ran %0d voxels in %0d columns under %0d threshold settings;",
                 voxels_sent, columns_sent, thr_settings);
        $display("%0d pixels checked, %0d long pixel hold-offs, %0d mismatches.",
                 pixels_checked, long_holds, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ first_hit_depth_colormap.f @@
+incdir+design
design/fhdc_pkg.sv
design/fhdc_voxel_if.sv
design/fhdc_pixel_if.sv
design/first_hit_depth_colormap.sv
tb/fhdc_pixel_checker.sv
tb/testbench.sv
